// ----- sv/efla_pkg.sv -----
// Shared types, codes and constants of the free-list heap allocator.
// No dependencies; every other file but efla_if imports this package.
package efla_pkg;

    localparam logic [15:0] SZ_MASK = 16'hFFF8;
    localparam logic [15:0] MIN_BLK = 16'd16;
    localparam logic [15:0] HDR_OVH = 16'd8;
    localparam logic [15:0] ALIGN_M = 16'd7;
    localparam logic [15:0] HEAD_RST = 16'd16;
    localparam logic [15:0] TOP_RST = 16'd32;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_OOM  = 2'd1,
        ST_IGN  = 2'd2
    } status_t;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    typedef enum logic [5:0] {
        S_INIT, S_IDLE, S_FIN, S_DONE,
        S_FF_CHK, S_FF_SZ, S_FF_NX,
        S_GROW, S_GROW_W1, S_GROW_W2,
        S_TAKE_RD, S_TAKE_SZ, S_TAKE_SPLIT, S_TN1, S_TS1, S_TS2, S_TS3,
        S_FR_CHK, S_FR_SZ, S_FR_W1,
        S_MG_RD0, S_MG_RD1, S_MG_RD2, S_MG_RD3, S_MG_NX, S_MG_PV, S_MG_PX,
        S_MG_W0, S_MG_W1, S_MG_W2, S_MG_W3, S_MG_W4,
        S_UL_RD0, S_UL_RD1, S_UL_RD2, S_UL_W
    } state_t;

    typedef struct packed {
        logic        we;
        logic [15:0] addr;
        logic [31:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic        valid;
        logic [13:0] addr;
        status_t     status;
    } result_t;

    // prologue, initial free block and epilogue, by word index
    function automatic logic [31:0] init_word(input logic [2:0] idx);
        logic [31:0] w;
        case (idx)
            3'd1: w = 32'd9;
            3'd2: w = 32'd9;
            3'd3: w = 32'd16;
            3'd6: w = 32'd16;
            3'd7: w = 32'd1;
            default: w = 32'd0;
        endcase
        return w;
    endfunction

endpackage

// ----- sv/efla_if.sv -----
// Handshake channels of the allocator: request and result.
// Depends on nothing.
interface efla_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [13:0] request_size;
    logic [13:0] block_address;
    modport source (output valid, kind, request_size, block_address, input ready);
    modport sink (input valid, kind, request_size, block_address, output ready);
endinterface

interface efla_rsp_if;
    logic        valid;
    logic        ready;
    logic [13:0] payload_address;
    logic [1:0]  status;
    modport source (output valid, payload_address, status, input ready);
    modport sink (input valid, payload_address, status, output ready);
endinterface

// ----- sv/efla_mem.sv -----
// Heap word store: one write or read port, registered read data.
// Depends on efla_pkg.
module efla_mem
    import efla_pkg::*;
#(
    parameter int HEAP_WORDS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  mem_req_t    mreq,
    output logic [31:0] rdata
);
    localparam int AW = $clog2(HEAP_WORDS);

    logic [31:0] mem [HEAP_WORDS];
    logic [31:0] rd_reg;
    logic        ok_reg;
    logic [31:0] widx;
    logic        in_range;

    assign widx = {18'd0, mreq.addr[15:2]};
    assign in_range = widx < 32'(HEAP_WORDS);
    assign rdata = ok_reg ? rd_reg : 32'd0;

    always_ff @(posedge clk)
    begin
        if (mreq.we && in_range)
        begin
            mem[widx[AW-1:0]] <= mreq.wdata;
        end
        rd_reg <= mem[widx[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg <= 1'b0;
        end
        else
        begin
            ok_reg <= in_range;
        end
    end
endmodule

// ----- sv/efla_seq.sv -----
// Sequencer of the allocator: list walk, block walk, split, grow,
// unlink and coalesce, at most one memory access per cycle. Depends on efla_pkg.
module efla_seq
    import efla_pkg::*;
#(
    parameter int HEAP_WORDS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic        req_kind,
    input  logic [13:0] req_size,
    input  logic [13:0] req_addr,
    input  logic        out_free,
    output result_t     done,
    output mem_req_t    mreq,
    input  logic [31:0] rdata
);
    localparam int CAP_I = (HEAP_WORDS * 4 > 16384) ? 16384 : HEAP_WORDS * 4;
    localparam int LIMIT = HEAP_WORDS / 4 + 1;
    localparam int NW = $clog2(LIMIT + 1);
    localparam logic [16:0] CAP = 17'(CAP_I);

    state_t state_reg, state_next, mret_reg, mret_next, uret_reg, uret_next;
    logic [15:0] p_reg, p_next, bp_reg, bp_next, sz_reg, sz_next;
    logic [15:0] as_reg, as_next, fs_reg, fs_next, pt_reg, pt_next, nt_reg, nt_next;
    logic [15:0] ux_reg, ux_next, nx_reg, nx_next, pv_reg, pv_next;
    logic [15:0] head_reg, head_next, top_reg, top_next, res_reg, res_next;
    logic [NW-1:0] n_reg, n_next;
    logic [2:0] ic_reg, ic_next;
    status_t st_reg, st_next;
    logic [15:0] rsz;
    logic [15:0] rnd;

    assign rsz = rdata[15:0] & SZ_MASK;
    assign rnd = ((16'(req_size) + ALIGN_M) & SZ_MASK) + HDR_OVH;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            mret_reg  <= S_DONE;
            uret_reg  <= S_DONE;
            head_reg  <= HEAD_RST;
            top_reg   <= TOP_RST;
            ic_reg    <= 3'd1;
        end
        else
        begin
            state_reg <= state_next;
            mret_reg  <= mret_next;
            uret_reg  <= uret_next;
            head_reg  <= head_next;
            top_reg   <= top_next;
            ic_reg    <= ic_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;   bp_reg <= bp_next; sz_reg <= sz_next;
        as_reg <= as_next; fs_reg <= fs_next; pt_reg <= pt_next;
        nt_reg <= nt_next; ux_reg <= ux_next; nx_reg <= nx_next;
        pv_reg <= pv_next; res_reg <= res_next; n_reg <= n_next;
        st_reg <= st_next;
    end

    always_comb
    begin
        state_next = state_reg; mret_next = mret_reg; uret_next = uret_reg;
        p_next = p_reg; bp_next = bp_reg; sz_next = sz_reg; as_next = as_reg;
        fs_next = fs_reg; pt_next = pt_reg; nt_next = nt_reg; ux_next = ux_reg;
        nx_next = nx_reg; pv_next = pv_reg; head_next = head_reg;
        top_next = top_reg; res_next = res_reg; n_next = n_reg;
        ic_next = ic_reg; st_next = st_reg;
        mreq = '{we: 1'b0, addr: 16'd0, wdata: 32'd0};
        req_ready = 1'b0;
        done = '{valid: 1'b0, addr: res_reg[13:0], status: st_reg};

        case (state_reg)
            S_INIT:
            begin
                mreq = '{we: 1'b1, addr: {11'd0, ic_reg, 2'b00}, wdata: init_word(ic_reg)};
                ic_next = ic_reg + 3'd1;
                if (ic_reg == 3'd7)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                res_next = 16'd0;
                n_next = '0;
                if (req_valid)
                begin
                    if (req_kind == KIND_ALLOC)
                    begin
                        as_next = (rnd < MIN_BLK) ? MIN_BLK : rnd;
                        p_next = head_reg;
                        if (req_size == 14'd0)
                        begin
                            st_next = ST_IGN;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            state_next = S_FF_CHK;
                        end
                    end
                    else
                    begin
                        bp_next = 16'(req_addr);
                        p_next = MIN_BLK;
                        if (req_addr == 14'd0)
                        begin
                            st_next = ST_IGN;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            state_next = S_FR_CHK;
                        end
                    end
                end
            end
            S_FF_CHK:
            begin
                mreq.addr = p_reg - 16'd4;
                state_next = (p_reg == 16'd0 || n_reg >= NW'(LIMIT)) ? S_GROW : S_FF_SZ;
            end
            S_FF_SZ:
            begin
                mreq.addr = p_reg;
                if (rsz >= as_reg)
                begin
                    bp_next = p_reg;
                    state_next = S_TAKE_RD;
                end
                else
                begin
                    state_next = S_FF_NX;
                end
            end
            S_FF_NX:
            begin
                p_next = rdata[15:0];
                n_next = n_reg + 1'b1;
                state_next = S_FF_CHK;
            end
            S_GROW:
            begin
                if ({1'b0, as_reg} > CAP || {1'b0, top_reg} > CAP - {1'b0, as_reg})
                begin
                    st_next = ST_OOM;
                    state_next = S_FIN;
                end
                else
                begin
                    bp_next = top_reg;
                    mreq = '{we: 1'b1, addr: top_reg - 16'd4, wdata: {16'd0, as_reg}};
                    state_next = S_GROW_W1;
                end
            end
            S_GROW_W1:
            begin
                mreq = '{we: 1'b1, addr: bp_reg + as_reg - 16'd8, wdata: {16'd0, as_reg}};
                state_next = S_GROW_W2;
            end
            S_GROW_W2:
            begin
                mreq = '{we: 1'b1, addr: bp_reg + as_reg - 16'd4, wdata: 32'd1};
                top_next = bp_reg + as_reg;
                mret_next = S_TAKE_RD;
                state_next = S_MG_RD0;
            end
            S_TAKE_RD:
            begin
                res_next = bp_reg;
                mreq.addr = bp_reg - 16'd4;
                state_next = S_TAKE_SZ;
            end
            S_TAKE_SZ:
            begin
                fs_next = rsz;
                ux_next = bp_reg;
                uret_next = S_TAKE_SPLIT;
                state_next = S_UL_RD0;
            end
            S_TAKE_SPLIT:
            begin
                if (fs_reg - as_reg >= MIN_BLK)
                begin
                    mreq = '{we: 1'b1, addr: bp_reg - 16'd4, wdata: {16'd0, as_reg | 16'd1}};
                    state_next = S_TS1;
                end
                else
                begin
                    mreq = '{we: 1'b1, addr: bp_reg - 16'd4, wdata: {16'd0, fs_reg | 16'd1}};
                    state_next = S_TN1;
                end
            end
            S_TN1:
            begin
                mreq = '{we: 1'b1, addr: bp_reg + fs_reg - 16'd8,
                         wdata: {16'd0, fs_reg | 16'd1}};
                state_next = S_DONE;
            end
            S_TS1:
            begin
                mreq = '{we: 1'b1, addr: bp_reg + as_reg - 16'd8,
                         wdata: {16'd0, as_reg | 16'd1}};
                state_next = S_TS2;
            end
            S_TS2:
            begin
                mreq = '{we: 1'b1, addr: bp_reg + as_reg - 16'd4,
                         wdata: {16'd0, fs_reg - as_reg}};
                state_next = S_TS3;
            end
            S_TS3:
            begin
                mreq = '{we: 1'b1, addr: bp_reg + fs_reg - 16'd8,
                         wdata: {16'd0, fs_reg - as_reg}};
                bp_next = bp_reg + as_reg;
                mret_next = S_DONE;
                state_next = S_MG_RD0;
            end
            S_FR_CHK:
            begin
                mreq.addr = p_reg - 16'd4;
                if (p_reg >= top_reg || n_reg >= NW'(LIMIT))
                begin
                    st_next = ST_IGN;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_FR_SZ;
                end
            end
            S_FR_SZ:
            begin
                if (rsz == 16'd0 || (p_reg == bp_reg && !rdata[0]))
                begin
                    st_next = ST_IGN;
                    state_next = S_FIN;
                end
                else if (p_reg == bp_reg)
                begin
                    sz_next = rsz;
                    mreq = '{we: 1'b1, addr: bp_reg - 16'd4, wdata: {16'd0, rsz}};
                    state_next = S_FR_W1;
                end
                else
                begin
                    p_next = p_reg + rsz;
                    n_next = n_reg + 1'b1;
                    state_next = S_FR_CHK;
                end
            end
            S_FR_W1:
            begin
                mreq = '{we: 1'b1, addr: bp_reg + sz_reg - 16'd8, wdata: {16'd0, sz_reg}};
                mret_next = S_DONE;
                state_next = S_MG_RD0;
            end
            // coalesce bp with free neighbors and push it on the list
            S_MG_RD0:
            begin
                mreq.addr = bp_reg - 16'd4;
                state_next = S_MG_RD1;
            end
            S_MG_RD1:
            begin
                sz_next = rsz;
                mreq.addr = bp_reg - 16'd8;
                state_next = S_MG_RD2;
            end
            S_MG_RD2:
            begin
                pt_next = rdata[15:0];
                mreq.addr = bp_reg + sz_reg - 16'd4;
                state_next = S_MG_RD3;
            end
            S_MG_RD3:
            begin
                nt_next = rdata[15:0];
                if (!rdata[0])
                begin
                    ux_next = bp_reg + sz_reg;
                    uret_next = S_MG_NX;
                    state_next = S_UL_RD0;
                end
                else
                begin
                    state_next = S_MG_PV;
                end
            end
            S_MG_NX:
            begin
                sz_next = sz_reg + (nt_reg & SZ_MASK);
                state_next = S_MG_PV;
            end
            S_MG_PV:
            begin
                if (!pt_reg[0])
                begin
                    ux_next = bp_reg - (pt_reg & SZ_MASK);
                    uret_next = S_MG_PX;
                    state_next = S_UL_RD0;
                end
                else
                begin
                    state_next = S_MG_W0;
                end
            end
            S_MG_PX:
            begin
                sz_next = sz_reg + (pt_reg & SZ_MASK);
                bp_next = bp_reg - (pt_reg & SZ_MASK);
                state_next = S_MG_W0;
            end
            S_MG_W0:
            begin
                mreq = '{we: 1'b1, addr: bp_reg - 16'd4, wdata: {16'd0, sz_reg}};
                state_next = S_MG_W1;
            end
            S_MG_W1:
            begin
                mreq = '{we: 1'b1, addr: bp_reg + sz_reg - 16'd8, wdata: {16'd0, sz_reg}};
                state_next = S_MG_W2;
            end
            S_MG_W2:
            begin
                mreq = '{we: 1'b1, addr: bp_reg, wdata: {16'd0, head_reg}};
                state_next = S_MG_W3;
            end
            S_MG_W3:
            begin
                mreq = '{we: 1'b1, addr: bp_reg + 16'd4, wdata: 32'd0};
                state_next = S_MG_W4;
            end
            S_MG_W4:
            begin
                mreq = '{we: head_reg != 16'd0, addr: head_reg + 16'd4,
                         wdata: {16'd0, bp_reg}};
                head_next = bp_reg;
                state_next = mret_reg;
            end
            // unlink ux from the free list
            S_UL_RD0:
            begin
                mreq.addr = ux_reg;
                state_next = S_UL_RD1;
            end
            S_UL_RD1:
            begin
                nx_next = rdata[15:0];
                mreq.addr = ux_reg + 16'd4;
                state_next = S_UL_RD2;
            end
            S_UL_RD2:
            begin
                pv_next = rdata[15:0];
                if (rdata[15:0] != 16'd0)
                begin
                    mreq = '{we: 1'b1, addr: rdata[15:0], wdata: {16'd0, nx_reg}};
                end
                else
                begin
                    head_next = nx_reg;
                end
                state_next = S_UL_W;
            end
            S_UL_W:
            begin
                mreq = '{we: nx_reg != 16'd0, addr: nx_reg + 16'd4, wdata: {16'd0, pv_reg}};
                state_next = uret_reg;
            end
            S_DONE:
            begin
                st_next = ST_DONE;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    done.valid = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ----- sv/explicit_free_list_allocator.sv -----
// Top level of the boundary-tag heap allocator: sequencer, word store and
// result register. Depends on efla_pkg, efla_if, efla_mem, efla_seq.
//
//  channel | dir | payload                          | handshake
//  req     | in  | kind, request_size, block_address | valid/ready
//  rsp     | out | payload_address, status          | valid/ready
//
// One transaction at a time, at most one store access per cycle. An allocate
// walks the free list and may split the block it takes or grow the heap;
// a free walks every block before it from the start of the heap. After
// reset a pass writes the initial layout before req.ready rises. A stalled
// rsp holds the next result in the sequencer until the result register
// drains.
module explicit_free_list_allocator
    import efla_pkg::*;
#(
    parameter int HEAP_WORDS = 4096
) (
    input logic       clk,
    input logic       rst_n,
    efla_req_if.sink  req,
    efla_rsp_if.source rsp
);
    mem_req_t    mreq;
    logic [31:0] rdata;
    result_t     done;
    logic        ovalid_reg;
    logic [13:0] oaddr_reg;
    status_t     ostat_reg;
    logic        out_free;

    assign out_free = !ovalid_reg || rsp.ready;

    efla_seq #(.HEAP_WORDS(HEAP_WORDS)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_kind  (req.kind),
        .req_size  (req.request_size),
        .req_addr  (req.block_address),
        .out_free  (out_free),
        .done      (done),
        .mreq      (mreq),
        .rdata     (rdata)
    );

    efla_mem #(.HEAP_WORDS(HEAP_WORDS)) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .mreq  (mreq),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (done.valid)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done.valid)
        begin
            oaddr_reg <= done.addr;
            ostat_reg <= done.status;
        end
    end

    assign rsp.valid = ovalid_reg;
    assign rsp.payload_address = oaddr_reg;
    assign rsp.status = ostat_reg;
endmodule

// ----- sv/efla_checker.sv -----
// Port-level checks of the allocator, bound to the top level.
// Depends on efla_pkg and explicit_free_list_allocator.
module efla_checker
    import efla_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [13:0] rsp_addr,
    input logic [1:0]  rsp_status
);
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_addr) && $stable(rsp_status))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready right after an accepted transaction");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_DONE |-> rsp_addr == 14'd0)
        else $error("address on a failed transaction");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_status == ST_DONE || rsp_status == ST_OOM || rsp_status == ST_IGN)
        else $error("bad status code");

    a_align: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_addr[2:0] == 3'd0)
        else $error("misaligned payload address");
endmodule

bind explicit_free_list_allocator efla_checker u_efla_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_addr   (rsp.payload_address),
    .rsp_status (rsp.status)
);
